// ----- hdl/chained_overflow_hash_table_assert.svh -----
// Assertion macros for the chained overflow hash table.
// Included by the top level; relies on clk_i and rst_ni in the using scope.
`ifndef CHAINED_OVERFLOW_HASH_TABLE_ASSERT_SVH
`define CHAINED_OVERFLOW_HASH_TABLE_ASSERT_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define CHT_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("implication check failed");
// Condition must never hold.
`define CHT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CHT_ASSERT_IMP(lbl, ant, con)
`define CHT_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- hdl/cht_pkg.sv -----
// Shared types and codes of the chained overflow hash table.
// No dependencies; used by every module of the block.
`default_nettype none
package cht_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    K_ADD  = 2'd0,
    K_FIND = 2'd1,
    K_DEL  = 2'd2,
    K_NONE = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_KEY_ZERO  = 2'd3
  } status_e;

  // Work the back end has to do for one item
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_DEL    = 2'd2,
    CMD_ANSWER = 2'd3
  } cmd_e;

  localparam int unsigned WordW    = 32;
  localparam int unsigned SlotIdxW = 9;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_e              cmd;
    status_e           status;  // answer for CMD_ANSWER
    logic [WordW-1:0]  key;
    logic [WordW-1:0]  app;
    logic [WordW-1:0]  tb;
    logic [WordW-1:0]  ex;
  } job_t;

  localparam int unsigned JobW = $bits(job_t);

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- hdl/cht_front.sv -----
// Front end: accepts items, computes the home slot and classifies them.
// Depends on cht_pkg.
`default_nettype none
module cht_front import cht_pkg::*; #(
  parameter int unsigned HOME_SLOTS  = 256,
  parameter int unsigned TOTAL_SLOTS = 512,
  parameter int unsigned SW          = 9
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             hold_i,      // back end still clearing
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       in_kind_i,
  input  wire logic [WordW-1:0] in_key_i,
  input  wire logic [WordW-1:0] in_app_i,
  input  wire logic [WordW-1:0] in_tb_i,
  input  wire logic [WordW-1:0] in_ex_i,
  output logic                  push_o,
  output job_t                  job_o,
  output logic [SW-1:0]         home_o,
  input  wire q_stat_t          q_stat_i
);

  localparam int unsigned HW = (HOME_SLOTS > 1) ? $clog2(HOME_SLOTS) : 1;
  localparam int unsigned AW = ((HW > SW) ? HW : SW) + 1;
  localparam int unsigned QuoW = WordW + 1 - HW;
  localparam bit HomePow2 = ((HOME_SLOTS & (HOME_SLOTS - 1)) == 0);
  // 2**(32+HW) / HOME_SLOTS rounded up; bit 32 is always set, the rest is kept
  localparam logic [63:0] Recip = ((64'd1 << (WordW + HW)) / 64'(HOME_SLOTS)) + 64'd1;
  localparam logic [WordW-1:0] RecipLo = Recip[WordW-1:0];

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e       state_q, state_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [HW-1:0]      rem_q, rem_d;
  logic [1:0]         kind_q;
  logic [WordW-1:0]   key_q, app_q, tb_q, ex_q;
  logic               take;
  logic [2*WordW-1:0] prod_q;
  logic [2*WordW:0]   qsum;
  logic [QuoW-1:0]    quo_q;
  logic [WordW-1:0]   quo_m;
  logic [AW-1:0]      home_ext;
  logic               in_range;

  assign in_ready_o = (state_q == F_IDLE) && !hold_i;
  assign take       = in_valid_i && in_ready_o;

  // Remainder by reciprocal multiplication: product, quotient, then key - q*M
  assign qsum  = {1'b0, key_q, {WordW{1'b0}}} + {1'b0, prod_q};
  assign quo_m = WordW'(quo_q) * WordW'(HOME_SLOTS);

  // Control
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (take) begin
          cnt_d = '0;
          if (HomePow2) begin
            rem_d   = in_key_i[HW-1:0];
            state_d = F_PUSH;
          end else begin
            rem_d   = '0;
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          rem_d   = HW'(key_q - quo_m);
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat_i.full) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Item payload and remainder pipeline
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    prod_q <= {{WordW{1'b0}}, key_q} * {{WordW{1'b0}}, RecipLo};
    quo_q  <= QuoW'(qsum >> (WordW + HW));
    if (take) begin
      kind_q <= in_kind_i;
      key_q  <= in_key_i;
      app_q  <= in_app_i;
      tb_q   <= in_tb_i;
      ex_q   <= in_ex_i;
    end
  end

  // Classification
  assign home_ext = AW'(rem_q);
  assign in_range = home_ext < AW'(TOTAL_SLOTS);
  assign home_o   = SW'(home_ext);

  always_comb begin
    job_o.key    = key_q;
    job_o.app    = app_q;
    job_o.tb     = tb_q;
    job_o.ex     = ex_q;
    job_o.cmd    = CMD_ANSWER;
    job_o.status = ST_NOT_FOUND;
    if (kind_q == K_NONE) begin
      job_o.status = ST_NOT_FOUND;
    end else if (key_q == '0) begin
      job_o.status = ST_KEY_ZERO;
    end else if (!in_range) begin
      job_o.status = (kind_q == K_ADD) ? ST_FULL : ST_NOT_FOUND;
    end else begin
      case (kind_q)
        K_ADD:   job_o.cmd = CMD_ADD;
        K_FIND:  job_o.cmd = CMD_FIND;
        default: job_o.cmd = CMD_DEL;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cht_fifo.sv -----
// Short queue between front and back end.
// Depends on cht_pkg.
`default_nettype none
module cht_fifo import cht_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      rdata_o,
  output q_stat_t           stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] buf_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign rdata_o      = buf_q[rp_q];
  assign stat_o.full  = (cnt_q == (PW+1)'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= wdata_i;
  end

endmodule
`default_nettype wire

// ----- hdl/cht_back.sv -----
// Back end: slot memory, clearing pass, chain walk and result register.
// Depends on cht_pkg.
`default_nettype none
module cht_back import cht_pkg::*; #(
  parameter int unsigned HOME_SLOTS  = 256,
  parameter int unsigned TOTAL_SLOTS = 512,
  parameter int unsigned SW          = 9
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  output logic                     clearing_o,
  input  wire q_stat_t             q_stat_i,
  input  wire job_t                q_job_i,
  input  wire logic [SW-1:0]       q_home_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output status_e                  out_status_o,
  output logic [SlotIdxW-1:0]      out_slot_o,
  output logic [WordW-1:0]         out_key_o,
  output logic [WordW-1:0]         out_app_o,
  output logic [WordW-1:0]         out_tb_o,
  output logic [WordW-1:0]         out_ex_o
);

  localparam int unsigned HW = (HOME_SLOTS > 1) ? $clog2(HOME_SLOTS) : 1;
  localparam int unsigned OW = ((HW > SW) ? HW : SW) + 1;
  localparam int unsigned LW = SW + 1;
  // Word layout from bit 0: key, app, titlebar, exit, enable, next link
  localparam int unsigned EnB = 4 * WordW;
  localparam int unsigned NxL = EnB + 1;
  localparam int unsigned MW  = NxL + LW;
  localparam logic [LW-1:0] NullLink = LW'(TOTAL_SLOTS);

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_READ  = 5'b00100,
    B_EVAL  = 5'b01000,
    B_RESP  = 5'b10000
  } back_state_e;

  logic [MW-1:0] mem [TOTAL_SLOTS];
  logic [MW-1:0] rd_q;

  back_state_e   state_q, state_d;
  logic [SW-1:0] clr_q, clr_d;
  logic [OW-1:0] nov_q, nov_d;
  logic [SW-1:0] a_q, a_d;
  job_t          job_q;
  logic          job_ld;

  logic          we, re;
  logic [SW-1:0] wa;
  logic [MW-1:0] wd;

  status_e          p_status_q, p_status_d;
  logic [SW-1:0]    p_slot_q, p_slot_d;
  logic [WordW-1:0] p_key_q, p_key_d, p_app_q, p_app_d;
  logic [WordW-1:0] p_tb_q, p_tb_d, p_ex_q, p_ex_d;
  logic             ov_q, ov_d, o_ld;

  logic [WordW-1:0] r_key;
  logic             r_en;
  logic [LW-1:0]    r_next;
  logic             r_link;
  logic             hit;

  assign r_key  = rd_q[WordW-1:0];
  assign r_en   = rd_q[EnB];
  assign r_next = rd_q[MW-1:NxL];
  assign r_link = r_next < NullLink;
  assign hit    = (r_key == job_q.key) && r_en;

  assign clearing_o = (state_q == B_CLEAR);

  // Chain walk control
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    nov_d      = nov_q;
    a_d        = a_q;
    pop_o      = 1'b0;
    job_ld     = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    wa         = a_q;
    wd         = rd_q;
    o_ld       = 1'b0;
    ov_d       = ov_q && !out_ready_i;
    p_status_d = p_status_q;
    p_slot_d   = p_slot_q;
    p_key_d    = p_key_q;
    p_app_d    = p_app_q;
    p_tb_d     = p_tb_q;
    p_ex_d     = p_ex_q;
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        wd    = {NullLink, {(NxL){1'b0}}};
        clr_d = clr_q + 1'b1;
        if (clr_q == SW'(TOTAL_SLOTS - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o      = 1'b1;
          job_ld     = 1'b1;
          a_d        = q_home_i;
          p_status_d = q_job_i.status;
          p_slot_d   = '0;
          p_key_d    = '0;
          p_app_d    = '0;
          p_tb_d     = '0;
          p_ex_d     = '0;
          state_d    = (q_job_i.cmd == CMD_ANSWER) ? B_RESP : B_READ;
        end
      end
      B_READ: begin
        re      = 1'b1;
        state_d = B_EVAL;
      end
      B_EVAL: begin
        state_d = B_RESP;
        if (job_q.cmd == CMD_ADD) begin
          if (r_key == '0) begin
            // empty slot: store the record here
            we         = 1'b1;
            wd         = {NullLink, 1'b1, job_q.ex, job_q.tb, job_q.app, job_q.key};
            p_status_d = ST_OK;
            p_slot_d   = a_q;
          end else if (r_link) begin
            a_d     = SW'(r_next);
            state_d = B_READ;
          end else if (nov_q >= OW'(TOTAL_SLOTS)) begin
            p_status_d = ST_FULL;
          end else begin
            // chain end: link a fresh overflow slot and move there
            we      = 1'b1;
            wd      = {LW'(nov_q), rd_q[NxL-1:0]};
            nov_d   = nov_q + 1'b1;
            a_d     = SW'(nov_q);
            state_d = B_READ;
          end
        end else begin
          if (hit) begin
            p_status_d = ST_OK;
            p_slot_d   = a_q;
            if (job_q.cmd == CMD_FIND) begin
              p_key_d = r_key;
              p_app_d = rd_q[2*WordW-1:WordW];
              p_tb_d  = rd_q[3*WordW-1:2*WordW];
              p_ex_d  = rd_q[4*WordW-1:3*WordW];
            end else begin
              we = 1'b1;
              wd = {r_next, 1'b0, rd_q[EnB-1:0]};
            end
          end else if (r_link) begin
            a_d     = SW'(r_next);
            state_d = B_READ;
          end else begin
            p_status_d = ST_NOT_FOUND;
          end
        end
      end
      B_RESP: begin
        if (!ov_q || out_ready_i) begin
          o_ld    = 1'b1;
          ov_d    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      nov_q   <= OW'(HOME_SLOTS);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nov_q   <= nov_d;
      ov_q    <= ov_d;
    end
  end

  // Job and result payload
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    p_status_q <= p_status_d;
    p_slot_q   <= p_slot_d;
    p_key_q    <= p_key_d;
    p_app_q    <= p_app_d;
    p_tb_q     <= p_tb_d;
    p_ex_q     <= p_ex_d;
    if (job_ld) job_q <= q_job_i;
    if (o_ld) begin
      out_status_o <= p_status_q;
      out_slot_o   <= SlotIdxW'(p_slot_q);
      out_key_o    <= p_key_q;
      out_app_o    <= p_app_q;
      out_tb_o     <= p_tb_q;
      out_ex_o     <= p_ex_q;
    end
  end

  assign out_valid_o = ov_q;

  // Slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[a_q];
  end

endmodule
`default_nettype wire

// ----- hdl/chained_overflow_hash_table.sv -----
// Chained overflow hash table of four-word records: the top level.
// Depends on cht_pkg, cht_front, cht_fifo, cht_back and the assertion header.
//
// Keyed store of TOTAL_SLOTS records. kind 0 adds, 1 finds, 2 deletes by key;
// the home slot is key modulo HOME_SLOTS and collisions chain into overflow
// slots handed out in order. Each item gives one result. After reset the slot
// memory is cleared, and no item is taken during the clearing pass.
// Steps per item: the front takes an item and pushes it to the queue; when
// HOME_SLOTS is not a power of two a reciprocal-multiply remainder unit
// (product, quotient, remainder) runs first. The back dispatches from idle,
// then reads and evaluates each chain slot visited (slot memory with one write
// and one registered read port) and loads the result register. The two halves
// overlap through a two-entry queue, and a result waiting in the output
// register does not stop new items being taken until the queue is full.
`default_nettype none
`include "chained_overflow_hash_table_assert.svh"
module chained_overflow_hash_table import cht_pkg::*; #(
  parameter int unsigned HOME_SLOTS  = 256,
  parameter int unsigned TOTAL_SLOTS = 512
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // key, app_word, titlebar_word, exit_word
  input  wire logic [1:0]   s_axis_tuser,   // kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata,   // slot_index, found_key, found_app,
                                            // found_titlebar, found_exit, zero pad
  output logic [1:0]        m_axis_tuser    // status
);

  localparam int unsigned SW    = $clog2(TOTAL_SLOTS);
  localparam int unsigned QW    = JobW + SW;
  localparam int unsigned QDEPTH = 2;

  logic             clearing;
  logic             push, pop;
  job_t             f_job, b_job;
  logic [SW-1:0]    f_home, b_home;
  logic [QW-1:0]    q_rdata;
  q_stat_t          q_stat;
  status_e          o_status;
  logic [SlotIdxW-1:0] o_slot;
  logic [WordW-1:0] o_key, o_app, o_tb, o_ex;

  cht_front #(
    .HOME_SLOTS(HOME_SLOTS),
    .TOTAL_SLOTS(TOTAL_SLOTS),
    .SW(SW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hold_i     (clearing),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_key_i   (s_axis_tdata[31:0]),
    .in_app_i   (s_axis_tdata[63:32]),
    .in_tb_i    (s_axis_tdata[95:64]),
    .in_ex_i    (s_axis_tdata[127:96]),
    .push_o     (push),
    .job_o      (f_job),
    .home_o     (f_home),
    .q_stat_i   (q_stat)
  );

  cht_fifo #(
    .W(QW),
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_home, f_job}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  assign b_job  = q_rdata[JobW-1:0];
  assign b_home = q_rdata[QW-1:JobW];

  cht_back #(
    .HOME_SLOTS(HOME_SLOTS),
    .TOTAL_SLOTS(TOTAL_SLOTS),
    .SW(SW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clearing_o   (clearing),
    .q_stat_i     (q_stat),
    .q_job_i      (b_job),
    .q_home_i     (b_home),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (o_status),
    .out_slot_o   (o_slot),
    .out_key_o    (o_key),
    .out_app_o    (o_app),
    .out_tb_o     (o_tb),
    .out_ex_o     (o_ex)
  );

  assign m_axis_tuser = o_status;
  assign m_axis_tdata = {7'd0, o_ex, o_tb, o_app, o_key, o_slot};

  // Checks
  `CHT_ASSERT_NEVER(a_push_full, push && q_stat.full)
  `CHT_ASSERT_NEVER(a_pop_empty, pop && q_stat.empty)
  `CHT_ASSERT_IMP(a_clear_stall, clearing, !s_axis_tready)
  `CHT_ASSERT_IMP(a_fail_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0)

endmodule
`default_nettype wire
